[rtl/spi_adc_pot_to_midi_cc_top_defines.svh]
// assertion macros for the rtl files of the pot to midi cc block; only the message queue uses them
`ifndef SPI_ADC_POT_TO_MIDI_CC_TOP_DEFINES_SVH
`define SPI_ADC_POT_TO_MIDI_CC_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every clock edge out of reset
`define SAPMC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SAPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SAPMC_ASSERT_IMP(lbl, ante, cons, msg)
`define SAPMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/sapmc_pkg.sv]
// types, constants and the value scaling function of the pot to midi cc block
`timescale 1ns / 1ps
package sapmc_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_STATUS  = 2'd0;
	localparam logic [1:0] CFG_BASE    = 2'd1;
	localparam logic [1:0] CFG_CEILING = 2'd2;

	// configuration reset values
	localparam logic [7:0] RST_STATUS  = 8'd176;
	localparam logic [6:0] RST_BASE    = 7'd32;
	localparam logic [6:0] RST_CEILING = 7'd121;

	// byte position within one outgoing message
	localparam logic [1:0] BYTE_STATUS = 2'd0;
	localparam logic [1:0] BYTE_CTRL   = 2'd1;
	localparam logic [1:0] BYTE_VALUE  = 2'd2;

	// message queue depth between front and back
	localparam int unsigned Q_DEPTH = 2;

	// level thresholds where ceil(0.042 * level) steps up
	localparam logic [6:0] STEP_1 = 7'd1;
	localparam logic [6:0] STEP_2 = 7'd24;
	localparam logic [6:0] STEP_3 = 7'd48;
	localparam logic [6:0] STEP_4 = 7'd72;
	localparam logic [6:0] STEP_5 = 7'd96;
	localparam logic [6:0] STEP_6 = 7'd120;
	localparam logic [7:0] VALUE_TOP = 8'd127;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [3:0] channel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] base;
		logic [6:0] ceiling;
	} cfg_t;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] ctrl;
		logic [6:0] value;
	} msg_t;

	// trunc((127000 - 1042*level) / 1000) saturated at zero, written as
	// 127 - level - ceil(42*level/1000)
	function automatic logic [6:0] scale_value(input logic [6:0] level);
		logic [2:0] steps;
		logic [7:0] sub;
		steps = {2'b00, level >= STEP_1} + {2'b00, level >= STEP_2}
			+ {2'b00, level >= STEP_3} + {2'b00, level >= STEP_4}
			+ {2'b00, level >= STEP_5} + {2'b00, level >= STEP_6};
		sub = {1'b0, level} + {5'b00000, steps};
		if (sub >= VALUE_TOP) begin
			return 7'd0;
		end
		return 7'(VALUE_TOP - sub);
	endfunction

endpackage

[rtl/sapmc_front.sv]
// front: pairs bytes into words, filters level changes, builds messages
`timescale 1ns / 1ps
module sapmc_front #(
	parameter int unsigned CHANNELS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sapmc_pkg::in_item_t in_data,
	input  sapmc_pkg::cfg_t     cfg,
	input  logic                q_full,
	output logic                push,
	output sapmc_pkg::msg_t     push_msg
);

	localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic             second_q;
	logic [7:0]       high_byte_q;
	logic [6:0]       last_level_q [CHANNELS];
	logic             falling_q    [CHANNELS];

	logic             accept;
	logic             ch_ok;
	logic [IDX_W-1:0] idx;
	logic [6:0]       raw_level;
	logic [6:0]       level;
	logic [6:0]       prev;
	logic             fall;
	logic             acc_up;
	logic             acc_down;

	// transfer whenever the queue has room
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// level from word bits 11..5, clamped to the ceiling
	assign raw_level = {high_byte_q[3:0], in_data.rx_byte[7:5]};
	assign level     = (raw_level > cfg.ceiling) ? cfg.ceiling : raw_level;

	// channel lookup
	assign ch_ok = {1'b0, in_data.channel} < 5'(CHANNELS);
	assign idx   = in_data.channel[IDX_W-1:0];
	assign prev  = last_level_q[idx];
	assign fall  = falling_q[idx];

	// hysteresis: a reversal needs a step of two
	always_comb begin
		if (fall) begin
			acc_up   = ({1'b0, prev} + 8'd1) < {1'b0, level};
			acc_down = prev > level;
		end else begin
			acc_up   = prev < level;
			acc_down = {1'b0, prev} > ({1'b0, level} + 8'd1);
		end
	end

	assign push = accept && second_q && ch_ok && (acc_up || acc_down);

	// outgoing message
	always_comb begin
		push_msg.status = cfg.status;
		push_msg.ctrl   = cfg.base + {3'b000, in_data.channel};
		push_msg.value  = sapmc_pkg::scale_value(level);
	end

	// byte pairing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q    <= 1'b0;
			high_byte_q <= 8'd0;
		end else if (accept) begin
			second_q <= !second_q;
			if (!second_q) begin
				high_byte_q <= in_data.rx_byte;
			end
		end
	end

	// per-channel level and direction store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_level_q[i] <= 7'd0;
				falling_q[i]    <= 1'b0;
			end
		end else if (push) begin
			last_level_q[idx] <= level;
			falling_q[idx]    <= !acc_up;
		end
	end

endmodule

[rtl/sapmc_fifo.sv]
// short message queue between front and back
`timescale 1ns / 1ps
`include "spi_adc_pot_to_midi_cc_top_defines.svh"
module sapmc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sapmc_pkg::msg_t push_msg,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output sapmc_pkg::msg_t head
);

	localparam int unsigned PTR_W = $clog2(sapmc_pkg::Q_DEPTH);
	localparam int unsigned CNT_W = $clog2(sapmc_pkg::Q_DEPTH + 1);

	sapmc_pkg::msg_t  entry_q [sapmc_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// status and head entry
	assign full  = count_q == CNT_W'(sapmc_pkg::Q_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_msg;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// queue checks
	`SAPMC_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
	`SAPMC_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`SAPMC_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CNT_W'(1), "count lost a push")

endmodule

[rtl/sapmc_back.sv]
// back: sends each queued message as three bytes through an output register
`timescale 1ns / 1ps
module sapmc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  sapmc_pkg::msg_t      head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sapmc_pkg::out_item_t out_data
);

	logic                 out_valid_q;
	sapmc_pkg::out_item_t out_data_q;
	logic [1:0]           byte_idx_q;
	logic                 load;
	sapmc_pkg::out_item_t next_item;

	// load when a byte is pending and the output register frees up
	assign load = !empty && (!out_valid_q || out_ready);
	assign pop  = load && (byte_idx_q == sapmc_pkg::BYTE_VALUE);

	// byte select
	always_comb begin
		case (byte_idx_q)
			sapmc_pkg::BYTE_STATUS: next_item = '{tx_byte: head.status, last: 1'b0};
			sapmc_pkg::BYTE_CTRL:   next_item = '{tx_byte: {1'b0, head.ctrl}, last: 1'b0};
			sapmc_pkg::BYTE_VALUE:  next_item = '{tx_byte: {1'b0, head.value}, last: 1'b1};
			default:                next_item = '{tx_byte: head.status, last: 1'b0};
		endcase
	end

	// byte counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q  <= sapmc_pkg::BYTE_STATUS;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				byte_idx_q  <= pop ? sapmc_pkg::BYTE_STATUS : byte_idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= next_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/spi_adc_pot_to_midi_cc_top.sv]
// A low byte that changes a level writes its message into the queue, whose head the
// back end loads into its output register; the three message bytes follow on
// consecutive cycles while out_ready stays high. Throughput: one input byte
// per cycle while the two-entry message queue has room; the back end sends one
// byte per cycle while out_ready is high. Reset clears pairing state, all channel
// levels and directions and the queue at once, and presets the config registers.
`timescale 1ns / 1ps
module spi_adc_pot_to_midi_cc_top #(
	parameter int unsigned CHANNELS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sapmc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sapmc_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [7:0]           cfg_data
);

	sapmc_pkg::cfg_t cfg_q;
	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	sapmc_pkg::msg_t push_msg;
	sapmc_pkg::msg_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.status  <= sapmc_pkg::RST_STATUS;
			cfg_q.base    <= sapmc_pkg::RST_BASE;
			cfg_q.ceiling <= sapmc_pkg::RST_CEILING;
		end else if (cfg_we) begin
			case (cfg_idx)
				sapmc_pkg::CFG_STATUS:  cfg_q.status  <= cfg_data;
				sapmc_pkg::CFG_BASE:    cfg_q.base    <= cfg_data[6:0];
				sapmc_pkg::CFG_CEILING: cfg_q.ceiling <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// byte pairing and change filter
	sapmc_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_msg (push_msg)
	);

	// message queue
	sapmc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_msg (push_msg),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	// message serializer
	sapmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[verif/tb_top.sv]
// testbench for the pot to midi cc block: directed table, random pairs, byte by byte checks
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int          DIR_ROWS      = 25;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// one directed row: a byte transfer or a register write
	typedef struct {
		row_kind_t  kind;
		logic [7:0] a;      // rx byte or register index
		logic [7:0] b;      // channel or register data
		bit         typed;  // expected message written out below
		bit         msg;    // typed row gives a message
		logic [7:0] st;
		logic [7:0] ctl;
		logic [7:0] val;
	} dir_row_t;

	dir_row_t dir_rows [DIR_ROWS] = '{
		// full scale word clamps to the ceiling, value bottoms out
		'{ROW_ITEM, 8'hFF, 8'd0,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'hFF, 8'd0,  1'b1, 1'b1, 8'd176, 8'd32, 8'd0},
		// equal level never gives a message
		'{ROW_ITEM, 8'h00, 8'd5,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h00, 8'd5,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		// channel sent with the low byte is the one used
		'{ROW_ITEM, 8'h0F, 8'd3,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'hE0, 8'd15, 1'b1, 1'b1, 8'd176, 8'd47, 8'd0},
		// top nibble of the word is ignored
		'{ROW_ITEM, 8'hF0, 8'd7,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h20, 8'd7,  1'b1, 1'b1, 8'd176, 8'd39, 8'd125},
		// reversal by one step is rejected
		'{ROW_ITEM, 8'h00, 8'd7,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h1F, 8'd7,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h00, 8'd7,  1'b0, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h60, 8'd7,  1'b0, 1'b0, 8'd0,   8'd0,  8'd0},
		// reversal by two is accepted
		'{ROW_ITEM, 8'h00, 8'd7,  1'b0, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h20, 8'd7,  1'b0, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h00, 8'd7,  1'b0, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h40, 8'd7,  1'b0, 1'b0, 8'd0,   8'd0,  8'd0},
		// falling by one keeps going, value at its top
		'{ROW_ITEM, 8'h00, 8'd7,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h00, 8'd7,  1'b1, 1'b1, 8'd176, 8'd39, 8'd127},
		// register extremes, base data bit 7 is dropped
		'{ROW_CFG,  {6'd0, sapmc_pkg::CFG_STATUS},  8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG,  {6'd0, sapmc_pkg::CFG_BASE},    8'hFF, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
		'{ROW_CFG,  {6'd0, sapmc_pkg::CFG_CEILING}, 8'h7F, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0},
		// controller number wraps, level above 121 saturates the value
		'{ROW_ITEM, 8'h0F, 8'd15, 1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'hFF, 8'd15, 1'b1, 1'b1, 8'd255, 8'd14, 8'd0},
		'{ROW_ITEM, 8'h0F, 8'd1,  1'b1, 1'b0, 8'd0,   8'd0,  8'd0},
		'{ROW_ITEM, 8'h40, 8'd1,  1'b1, 1'b1, 8'd255, 8'd0,  8'd0}
	};

	// dut ports
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	sapmc_pkg::in_item_t  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	sapmc_pkg::out_item_t out_data;
	logic                 cfg_we    = 1'b0;
	logic [1:0]           cfg_idx   = '0;
	logic [7:0]           cfg_data  = '0;

	// predictor state
	logic [7:0] cfg_status;
	logic [6:0] cfg_base;
	logic [6:0] cfg_ceiling;
	bit         low_byte_next;
	logic [7:0] held_high;
	logic [6:0] chan_level   [16];
	bit         chan_falling [16];

	sapmc_pkg::out_item_t cc_bytes_due [$];
	int unsigned fail_count    = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 37;
	int unsigned recv_idle_pct = 71;

	spi_adc_pot_to_midi_cc_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// output side: random stalls, compare each transfer with the oldest expected byte
	always @(posedge clk) begin
		sapmc_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cc_bytes_due.size() == 0) begin
					$error("unexpected output byte %0d last %0d", out_data.tx_byte,
						out_data.last);
					fail_count++;
				end else begin
					want = cc_bytes_due.pop_front();
					if (out_data.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %0d, actual %0d", want.tx_byte,
							out_data.tx_byte);
						fail_count++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, out_data.last);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// value byte: trunc((127000 - 1042*level) / 1000), never below zero
	function automatic logic [7:0] cc_value(input logic [6:0] lvl);
		int num;
		num = 127000 - 1042 * int'(lvl);
		if (num <= 0) begin
			return 8'd0;
		end
		return 8'(num / 1000);
	endfunction

	// advance the predictor by one accepted byte
	task automatic take_byte(input sapmc_pkg::in_item_t it, output bit emitted,
		output logic [7:0] st, output logic [7:0] ctl, output logic [7:0] val);
		logic [15:0] word;
		logic [6:0]  lvl;
		logic [6:0]  prev;
		bit          up;
		bit          down;
		emitted = 1'b0;
		st = '0;
		ctl = '0;
		val = '0;
		if (!low_byte_next) begin
			held_high = it.rx_byte;
			low_byte_next = 1'b1;
		end else begin
			low_byte_next = 1'b0;
			word = {held_high, it.rx_byte};
			lvl = word[11:5];
			if (lvl > cfg_ceiling) begin
				lvl = cfg_ceiling;
			end
			// all 16 channel codes are in range for this build
			prev = chan_level[it.channel];
			if (chan_falling[it.channel]) begin
				up = ({1'b0, prev} + 8'd1) < {1'b0, lvl};
				down = prev > lvl;
			end else begin
				up = prev < lvl;
				down = {1'b0, prev} > ({1'b0, lvl} + 8'd1);
			end
			if (up || down) begin
				chan_falling[it.channel] = !up;
				chan_level[it.channel] = lvl;
				emitted = 1'b1;
				st = cfg_status;
				ctl = {1'b0, 7'(cfg_base + {3'b000, it.channel})};
				val = cc_value(lvl);
			end
		end
	endtask

	task automatic queue_msg(input logic [7:0] st, input logic [7:0] ctl,
		input logic [7:0] val);
		cc_bytes_due.push_back('{tx_byte: st, last: 1'b0});
		cc_bytes_due.push_back('{tx_byte: ctl, last: 1'b0});
		cc_bytes_due.push_back('{tx_byte: val, last: 1'b1});
	endtask

	// input transfer with random gaps, then prediction
	task automatic feed(input sapmc_pkg::in_item_t it, input bit use_pred);
		bit         emitted;
		logic [7:0] st;
		logic [7:0] ctl;
		logic [7:0] val;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		take_byte(it, emitted, st, ctl, val);
		if (use_pred && emitted) begin
			queue_msg(st, ctl, val);
		end
	endtask

	// register write, one per cycle, predictor follows at the same edge
	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			sapmc_pkg::CFG_STATUS: begin
				cfg_status = data;
			end
			sapmc_pkg::CFG_BASE: begin
				cfg_base = data[6:0];
			end
			sapmc_pkg::CFG_CEILING: begin
				cfg_ceiling = data[6:0];
			end
			default: begin
			end
		endcase
	endtask

	// wait for all expected bytes, then for any rejected word still in flight
	task automatic drain();
		in_valid <= 1'b0;
		while (cc_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_random();
		cfg_write(sapmc_pkg::CFG_STATUS, 8'($urandom));
		cfg_write(sapmc_pkg::CFG_BASE, 8'($urandom));
		cfg_write(sapmc_pkg::CFG_CEILING, {1'($urandom), 7'($urandom_range(40, 127))});
		cfg_we <= 1'b0;
	endtask

	// mostly well formed pairs near the stored level, some stray bytes
	task automatic run_phase(input int unsigned n_items);
		int unsigned         sent;
		sapmc_pkg::in_item_t it;
		logic [3:0]          ch;
		logic [6:0]          lvl;
		logic [15:0]         word;
		int                  target;
		sent = 0;
		while (sent < n_items) begin
			if (low_byte_next || $urandom_range(0, 9) == 0) begin
				// stray byte, or the one that closes a broken pair
				it.rx_byte = 8'($urandom);
				it.channel = 4'($urandom);
				feed(it, 1'b1);
				sent++;
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					ch = 4'($urandom_range(0, 3));
				end else begin
					ch = 4'($urandom);
				end
				if ($urandom_range(0, 9) < 7) begin
					// small steps around the threshold of a reversal
					target = int'(chan_level[ch]) + int'($urandom_range(0, 6)) - 3;
					if (target < 0) begin
						target = 0;
					end
					if (target > 127) begin
						target = 127;
					end
					lvl = 7'(target);
				end else begin
					lvl = 7'($urandom);
				end
				word = {4'($urandom), lvl, 5'($urandom)};
				it.rx_byte = word[15:8];
				it.channel = ($urandom_range(0, 7) == 0) ? 4'($urandom) : ch;
				feed(it, 1'b1);
				it.rx_byte = word[7:0];
				it.channel = ch;
				feed(it, 1'b1);
				sent += 2;
			end
		end
	endtask

	// main sequence
	initial begin
		sapmc_pkg::in_item_t it;
		bit                  in_cfg;
		cfg_status = sapmc_pkg::RST_STATUS;
		cfg_base = sapmc_pkg::RST_BASE;
		cfg_ceiling = sapmc_pkg::RST_CEILING;
		low_byte_next = 1'b0;
		held_high = '0;
		for (int i = 0; i < 16; i++) begin
			chan_level[i] = '0;
			chan_falling[i] = 1'b0;
		end
		in_cfg = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!in_cfg) begin
					drain();
				end
				in_cfg = 1'b1;
				cfg_write(dir_rows[i].a[1:0], dir_rows[i].b);
			end else begin
				if (in_cfg) begin
					cfg_we <= 1'b0;
				end
				in_cfg = 1'b0;
				it.rx_byte = dir_rows[i].a;
				it.channel = dir_rows[i].b[3:0];
				feed(it, !dir_rows[i].typed);
				if (dir_rows[i].typed && dir_rows[i].msg) begin
					queue_msg(dir_rows[i].st, dir_rows[i].ctl, dir_rows[i].val);
				end
			end
		end
		drain();

		// random phases across settings and idling patterns
		cfg_random();
		run_phase(150);
		drain();

		send_idle_pct = 71;
		recv_idle_pct = 37;
		cfg_write(sapmc_pkg::CFG_STATUS, 8'h00);
		cfg_write(sapmc_pkg::CFG_BASE, 8'h00);
		cfg_write(sapmc_pkg::CFG_CEILING, 8'h00);
		cfg_we <= 1'b0;
		run_phase(40);
		drain();

		cfg_write(sapmc_pkg::CFG_STATUS, 8'hFF);
		cfg_write(sapmc_pkg::CFG_BASE, 8'h7F);
		cfg_write(sapmc_pkg::CFG_CEILING, 8'hFF);
		cfg_we <= 1'b0;
		run_phase(130);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		cfg_random();
		run_phase(130);
		drain();

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/sapmc_pkg.sv
rtl/sapmc_front.sv
rtl/sapmc_fifo.sv
rtl/sapmc_back.sv
rtl/spi_adc_pot_to_midi_cc_top.sv
verif/tb_top.sv
